// ----- src/assert_macros.svh -----
// Assertion macros used by the top module of the slot pool block.
// Every macro samples on the rising edge of clock and is off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds on every clock edge.
`define PSRQ_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Check a consequence in the same cycle as its antecedent.
`define PSRQ_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define PSRQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/psrq_pkg.sv -----
// Shared types and constants of the process slot pool and ready queue.
// Used by every module of the block; depends on nothing.
`default_nettype none

package psrq_pkg;

   // Field widths of the request and response words
   localparam int FUNC_W        = 3;
   localparam int SLOT_W        = 3;
   localparam int STATUS_W      = 2;
   localparam int REQ_TDATA_W   = 8;
   localparam int RSP_TDATA_W   = 8;
   localparam int SLOT_COUNT_DEF = 8;

   // Request functions
   typedef enum logic [FUNC_W-1:0] {
      FUNC_ALLOC   = 3'd0,
      FUNC_RELEASE = 3'd1,
      FUNC_ENQ     = 3'd2,
      FUNC_DEQ     = 3'd3,
      FUNC_UNLINK  = 3'd4
   } func_type;

   // Response status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_BAD   = 2'd2
   } status_type;

   // Sequencer states
   typedef enum logic [1:0] {
      STATE_IDLE = 2'b01,
      STATE_EXEC = 2'b10
   } state_type;

   // Flag update command to the slot table
   typedef struct packed {
      logic set_alloc;
      logic clr_alloc;
      logic set_queued;
      logic clr_queued;
   } flag_cmd_type;

endpackage

`default_nettype wire

// ----- src/process_slot_pool_ready_queue_top.sv -----
// Process slot pool with a doubly linked ready FIFO threaded through the slots.
// Each request word (allocate, release, enqueue, dequeue, unlink) gives one response
// word with a slot and a status. On accept the next and prev link memories are read
// into registered read data; the update state then writes links, marks and the
// head and tail pointers. The response sits in an output register; a new request is
// taken while it waits, and the update cycle holds only if that register is still full.
// Depends on psrq_pkg, psrq_flags, psrq_links and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module process_slot_pool_ready_queue_top #(
   parameter int SLOT_COUNT = psrq_pkg::SLOT_COUNT_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // [2:0] func, [5:3] slot, [7:6] zero
   input  wire logic [psrq_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [2:0] result_slot, [4:3] status, [7:5] zero
   output logic      [psrq_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   localparam int IDX_W  = $clog2(SLOT_COUNT);
   localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
   localparam int WIDE_W = (CNT_W > psrq_pkg::SLOT_W) ? CNT_W : psrq_pkg::SLOT_W;
   localparam int PAD_W  = psrq_pkg::RSP_TDATA_W - psrq_pkg::SLOT_W - psrq_pkg::STATUS_W;

   psrq_pkg::state_type  state_ff, state_in;
   psrq_pkg::func_type   func_ff;
   logic [psrq_pkg::SLOT_W-1:0] slot_ff;
   logic [IDX_W-1:0]     head_ff, head_in;
   logic [IDX_W-1:0]     tail_ff, tail_in;
   logic                 rsp_valid_ff;
   logic [psrq_pkg::SLOT_W-1:0] rsp_slot_ff;
   psrq_pkg::status_type rsp_status_ff;

   psrq_pkg::func_type   req_func;
   logic [psrq_pkg::SLOT_W-1:0] req_slot;
   logic [IDX_W-1:0]     req_idx;
   logic                 req_accept;
   logic                 exec_done;

   logic [WIDE_W-1:0]    slot_wide;
   logic                 slot_ok;
   logic [IDX_W-1:0]     slot_idx;
   logic [IDX_W-1:0]     cur_idx;
   logic                 at_head, at_tail, q_empty, detach;

   psrq_pkg::flag_cmd_type flag_cmd, flag_cmd_go;
   logic [IDX_W-1:0]     flag_idx;
   logic [SLOT_COUNT-1:0] allocated, queued;
   logic                 free_found;
   logic [IDX_W-1:0]     free_idx;

   logic [IDX_W-1:0]     next_raddr, next_rdata, prev_rdata;
   logic                 next_we, prev_we;
   logic [IDX_W-1:0]     next_waddr, next_wdata, prev_waddr, prev_wdata;
   logic [IDX_W-1:0]     res_idx;
   psrq_pkg::status_type res_status;

   // Unpack the request word
   assign req_func   = psrq_pkg::func_type'(req_tdata[psrq_pkg::FUNC_W-1:0]);
   assign req_slot   = req_tdata[psrq_pkg::FUNC_W+psrq_pkg::SLOT_W-1:psrq_pkg::FUNC_W];
   assign req_idx    = IDX_W'(WIDE_W'(req_slot));
   assign req_tready = (state_ff == psrq_pkg::STATE_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign exec_done  = (state_ff == psrq_pkg::STATE_EXEC) && (!rsp_valid_ff || rsp_tready);

   // Read the next link of the head for a dequeue, else of the operand slot; prev is always of the operand slot
   assign next_raddr = (req_func == psrq_pkg::FUNC_DEQ) ? head_ff : req_idx;

   // Operand slot range check
   assign slot_wide = WIDE_W'(slot_ff);
   assign slot_ok   = slot_wide < WIDE_W'(SLOT_COUNT);
   assign slot_idx  = IDX_W'(slot_wide);
   assign q_empty   = ~|queued;
   assign cur_idx   = (func_ff == psrq_pkg::FUNC_DEQ) ? head_ff : slot_idx;
   assign at_head   = (cur_idx == head_ff);
   assign at_tail   = (cur_idx == tail_ff);

   // Work out the updates and the response of the held request
   always_comb begin
      head_in    = head_ff;
      tail_in    = tail_ff;
      flag_cmd   = '0;
      flag_idx   = cur_idx;
      next_we    = 1'b0;
      next_waddr = prev_rdata;
      next_wdata = next_rdata;
      prev_we    = 1'b0;
      prev_waddr = next_rdata;
      prev_wdata = prev_rdata;
      res_idx    = '0;
      res_status = psrq_pkg::STATUS_BAD;
      detach     = 1'b0;
      case (func_ff)
         psrq_pkg::FUNC_ALLOC: begin
            if (free_found) begin
               flag_idx           = free_idx;
               flag_cmd.set_alloc = 1'b1;
               res_idx            = free_idx;
               res_status         = psrq_pkg::STATUS_OK;
            end else begin
               res_status = psrq_pkg::STATUS_EMPTY;
            end
         end
         psrq_pkg::FUNC_RELEASE: begin
            if (slot_ok && allocated[slot_idx] && !queued[slot_idx]) begin
               flag_cmd.clr_alloc = 1'b1;
               res_idx            = slot_idx;
               res_status         = psrq_pkg::STATUS_OK;
            end
         end
         psrq_pkg::FUNC_ENQ: begin
            if (slot_ok && !queued[slot_idx]) begin
               flag_cmd.set_queued = 1'b1;
               tail_in             = slot_idx;
               res_idx             = slot_idx;
               res_status          = psrq_pkg::STATUS_OK;
               if (q_empty) begin
                  head_in = slot_idx;
               end else begin
                  next_we    = 1'b1;
                  next_waddr = tail_ff;
                  next_wdata = slot_idx;
                  prev_we    = 1'b1;
                  prev_waddr = slot_idx;
                  prev_wdata = tail_ff;
               end
            end
         end
         psrq_pkg::FUNC_DEQ: begin
            if (q_empty) begin
               res_status = psrq_pkg::STATUS_EMPTY;
            end else begin
               detach = 1'b1;
            end
         end
         psrq_pkg::FUNC_UNLINK: begin
            if (slot_ok && queued[slot_idx]) begin
               detach = 1'b1;
            end
         end
         default: begin
         end
      endcase
      // Unlink the current slot; head and tail need no stored link
      if (detach) begin
         flag_cmd.clr_queued = 1'b1;
         res_idx             = cur_idx;
         res_status          = psrq_pkg::STATUS_OK;
         if (at_head) begin
            head_in = next_rdata;
         end else begin
            next_we = 1'b1;
         end
         if (at_tail) begin
            tail_in = prev_rdata;
         end else begin
            prev_we = 1'b1;
         end
      end
   end

   assign flag_cmd_go = exec_done ? flag_cmd : '0;

   // Sequencer: read cycle on accept, update cycle after
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         psrq_pkg::STATE_IDLE: begin
            if (req_accept) begin
               state_in = psrq_pkg::STATE_EXEC;
            end
         end
         psrq_pkg::STATE_EXEC: begin
            if (exec_done) begin
               state_in = psrq_pkg::STATE_IDLE;
            end
         end
         default: begin
            state_in = psrq_pkg::STATE_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= psrq_pkg::STATE_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (exec_done) begin
            head_ff      <= head_in;
            tail_ff      <= tail_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Hold the request and the response payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         func_ff <= req_func;
         slot_ff <= req_slot;
      end
      if (exec_done) begin
         rsp_slot_ff   <= psrq_pkg::SLOT_W'(res_idx);
         rsp_status_ff <= res_status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_status_ff, rsp_slot_ff};

   psrq_flags #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_flags (
      .clock      (clock),
      .reset      (reset),
      .cmd        (flag_cmd_go),
      .cmd_idx    (flag_idx),
      .allocated  (allocated),
      .queued     (queued),
      .free_found (free_found),
      .free_idx   (free_idx)
   );

   psrq_links #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_links (
      .clock      (clock),
      .rd_en      (req_accept),
      .next_raddr (next_raddr),
      .prev_raddr (req_idx),
      .next_rdata (next_rdata),
      .prev_rdata (prev_rdata),
      .next_we    (next_we && exec_done),
      .next_waddr (next_waddr),
      .next_wdata (next_wdata),
      .prev_we    (prev_we && exec_done),
      .prev_waddr (prev_waddr),
      .prev_wdata (prev_wdata)
   );

   // Head and tail point at queued slots whenever the queue holds any
   `PSRQ_ASSERT_IMPLIES(a_ends_queued, !q_empty, queued[head_ff] && queued[tail_ff], "queue end not marked queued")
   // A single queued slot is both head and tail
   `PSRQ_ASSERT_IMPLIES(a_single_entry, $countones(queued) == 1, head_ff == tail_ff, "single entry with head apart from tail")
   // An accepted word is followed by its update cycle, with input closed
   `PSRQ_ASSERT_NEXT(a_accept_exec, req_accept, state_ff == psrq_pkg::STATE_EXEC && !req_tready, "accept without update cycle")
   // A failed request reports slot zero
   `PSRQ_ASSERT_ALWAYS(a_fail_zero, !rsp_valid_ff || rsp_status_ff == psrq_pkg::STATUS_OK || rsp_slot_ff == '0, "non-zero slot on failed request")

endmodule

`default_nettype wire

// ----- src/psrq_flags.sv -----
// Slot table: allocated and queued marks per slot, plus the lowest-free search.
// Depends on psrq_pkg for the flag command struct.
`default_nettype none

module psrq_flags #(
   parameter int SLOT_COUNT = psrq_pkg::SLOT_COUNT_DEF,
   localparam int IDX_W = $clog2(SLOT_COUNT)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire psrq_pkg::flag_cmd_type cmd,
   input  wire logic [IDX_W-1:0]       cmd_idx,
   output logic [SLOT_COUNT-1:0]       allocated,
   output logic [SLOT_COUNT-1:0]       queued,
   output logic                        free_found,
   output logic [IDX_W-1:0]            free_idx
);

   logic [SLOT_COUNT-1:0] alloc_ff;
   logic [SLOT_COUNT-1:0] queued_ff;

   // Apply the marks of the finishing request
   always_ff @(posedge clock) begin
      if (reset) begin
         alloc_ff  <= '0;
         queued_ff <= '0;
      end else begin
         if (cmd.set_alloc) begin
            alloc_ff[cmd_idx] <= 1'b1;
         end
         if (cmd.clr_alloc) begin
            alloc_ff[cmd_idx] <= 1'b0;
         end
         if (cmd.set_queued) begin
            queued_ff[cmd_idx] <= 1'b1;
         end
         if (cmd.clr_queued) begin
            queued_ff[cmd_idx] <= 1'b0;
         end
      end
   end

   // Find the lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (!alloc_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   assign allocated = alloc_ff;
   assign queued    = queued_ff;

endmodule

`default_nettype wire

// ----- src/psrq_links.sv -----
// Link store: next and prev pointer memories of the ready queue.
// Synchronous write, registered read; depends on psrq_pkg for defaults.
`default_nettype none

module psrq_links #(
   parameter int SLOT_COUNT = psrq_pkg::SLOT_COUNT_DEF,
   localparam int IDX_W = $clog2(SLOT_COUNT)
) (
   input  wire logic             clock,
   input  wire logic             rd_en,
   input  wire logic [IDX_W-1:0] next_raddr,
   input  wire logic [IDX_W-1:0] prev_raddr,
   output logic      [IDX_W-1:0] next_rdata,
   output logic      [IDX_W-1:0] prev_rdata,
   input  wire logic             next_we,
   input  wire logic [IDX_W-1:0] next_waddr,
   input  wire logic [IDX_W-1:0] next_wdata,
   input  wire logic             prev_we,
   input  wire logic [IDX_W-1:0] prev_waddr,
   input  wire logic [IDX_W-1:0] prev_wdata
);

   // Read values of slots off the queue are never used, so no clearing is needed
   logic [IDX_W-1:0] next_link_ff [SLOT_COUNT];
   logic [IDX_W-1:0] prev_link_ff [SLOT_COUNT];
   logic [IDX_W-1:0] next_rdata_ff;
   logic [IDX_W-1:0] prev_rdata_ff;

   // Write the updated links
   always_ff @(posedge clock) begin
      if (next_we) begin
         next_link_ff[next_waddr] <= next_wdata;
      end
      if (prev_we) begin
         prev_link_ff[prev_waddr] <= prev_wdata;
      end
   end

   // Read both links of the addressed slots; hold until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         next_rdata_ff <= next_link_ff[next_raddr];
         prev_rdata_ff <= prev_link_ff[prev_raddr];
      end
   end

   assign next_rdata = next_rdata_ff;
   assign prev_rdata = prev_rdata_ff;

endmodule

`default_nettype wire
